// ===== hw/rtl/shapad_pkg.sv =====
package shapad_pkg;

    localparam int COUNT_W = 61;
    localparam int LEN_W = 64;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [7:0] PAD_ZERO = 8'h00;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [1:0] WORD_LAST_BYTE = 2'd3;
    localparam logic [2:0] LEN_LAST_BYTE = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN
    } t_state;

    typedef struct packed {
        logic       step;
        logic       clear;
        logic       last;
        logic [7:0] data;
    } t_pack_ctrl;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
    } t_pack_stat;

endpackage

// ===== hw/rtl/shapad_in_if.sv =====
interface shapad_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_message;

    modport source (output valid, output data_byte, output last_byte,
                    output empty_message, input ready);
    modport sink (input valid, input data_byte, input last_byte,
                  input empty_message, output ready);
endinterface

// ===== hw/rtl/shapad_out_if.sv =====
interface shapad_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_word;
    logic        last_word;

    modport source (output valid, output block_word, output last_word, input ready);
    modport sink (input valid, input block_word, input last_word, output ready);
endinterface

// ===== hw/rtl/shapad_packer.sv =====
module shapad_packer
    import shapad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pack_ctrl  i_ctrl,
    output t_pack_stat  o_stat,
    output logic        o_emit,
    output logic [31:0] o_word
);

    logic [23:0]        r_partial;
    logic [COUNT_W-1:0] r_count;
    logic [23:0]        n_partial;
    logic [COUNT_W-1:0] n_count;
    logic               word_done;

    assign word_done = (r_count[1:0] == WORD_LAST_BYTE);
    assign o_emit = i_ctrl.step && word_done;
    assign o_word = {r_partial, i_ctrl.data};
    assign o_stat.count = r_count;

    always_comb begin
        n_partial = r_partial;
        n_count = r_count;
        if (i_ctrl.step) begin
            n_partial = word_done ? 24'd0 : {r_partial[15:0], i_ctrl.data};
            n_count = i_ctrl.clear ? '0 : r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_count <= '0;
        end else begin
            r_partial <= n_partial;
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/shapad_seq.sv =====
module shapad_seq
    import shapad_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_empty_message,
    input  logic       i_slot_free,
    input  t_pack_stat i_stat,
    output logic       o_ready,
    output t_pack_ctrl o_ctrl
);

    t_state           r_state;
    t_state           n_state;
    logic [LEN_W-1:0] r_len_bits;
    logic [2:0]       r_len_idx;
    logic             accept;
    logic             can_step;

    assign accept = i_valid && o_ready;
    assign can_step = i_slot_free || (i_stat.count[1:0] != WORD_LAST_BYTE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_empty_message || i_last_byte)) begin
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                if (o_ctrl.step) begin
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (i_stat.count[5:0] == LEN_POS) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (o_ctrl.step && (r_len_idx == LEN_LAST_BYTE)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_ctrl.step = 1'b0;
        o_ctrl.clear = 1'b0;
        o_ctrl.last = 1'b0;
        o_ctrl.data = PAD_ZERO;
        case (r_state)
            ST_IDLE: begin
                o_ready = i_slot_free;
                o_ctrl.step = accept && !i_empty_message;
                o_ctrl.data = i_data_byte;
            end
            ST_MARK: begin
                o_ctrl.step = can_step;
                o_ctrl.data = PAD_MARK;
            end
            ST_ZERO: begin
                o_ctrl.step = can_step && (i_stat.count[5:0] != LEN_POS);
            end
            ST_LEN: begin
                o_ctrl.step = can_step;
                o_ctrl.data = r_len_bits[LEN_W-1 -: 8];
                o_ctrl.last = (r_len_idx == LEN_LAST_BYTE);
                o_ctrl.clear = o_ctrl.last;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MARK && o_ctrl.step) begin
                r_len_idx <= '0;
            end else if (r_state == ST_LEN && o_ctrl.step) begin
                r_len_idx <= r_len_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MARK && o_ctrl.step) begin
            r_len_bits <= {i_stat.count, 3'b000};
        end else if (r_state == ST_LEN && o_ctrl.step) begin
            r_len_bits <= {r_len_bits[LEN_W-9:0], PAD_ZERO};
        end
    end

endmodule

// ===== hw/rtl/sha256_message_padder.sv =====
// Packs a message, one byte per input item, into big-endian 32-bit words and
// appends the SHA-256 padding and the 64-bit bit length when the message ends.
// The input channel carries data_byte, last_byte and empty_message; an item
// with empty_message set carries no byte and ends the message at once.
// The output channel carries block_word and last_word, which marks the final
// word of the padded message.
// Message bytes are taken one per cycle while the output register is free.
// A word appears in the output register the cycle after the item that supplies
// its fourth byte. After a final item the byte sequencer feeds the shared byte
// packer one pad byte per cycle unless it would complete a word while the
// output register is full: the 0x80 mark, zero bytes up to position 56 of the
// block, a length turn and eight length bytes. No item is taken meanwhile.
// The output register holds one word. While the receiver stalls, the packer
// waits whenever its next byte would complete a word, so nothing is dropped.
// A synchronous reset clears the byte count, the partial word and the output
// valid flag, and the block starts a new message.
module sha256_message_padder
    import shapad_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    shapad_in_if.sink    i_in,
    shapad_out_if.source o_out
);

    t_pack_ctrl  pack_ctrl;
    t_pack_stat  pack_stat;
    logic        pack_emit;
    logic [31:0] pack_word;
    logic        slot_free;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic        r_out_last;

    assign slot_free = !r_out_valid || o_out.ready;

    shapad_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in.valid),
        .i_data_byte     (i_in.data_byte),
        .i_last_byte     (i_in.last_byte),
        .i_empty_message (i_in.empty_message),
        .i_slot_free     (slot_free),
        .i_stat          (pack_stat),
        .o_ready         (i_in.ready),
        .o_ctrl          (pack_ctrl)
    );

    shapad_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (pack_ctrl),
        .o_stat  (pack_stat),
        .o_emit  (pack_emit),
        .o_word  (pack_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pack_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pack_emit) begin
            r_out_word <= pack_word;
            r_out_last <= pack_ctrl.last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.block_word = r_out_word;
    assign o_out.last_word = r_out_last;

endmodule

// ===== test/tb_sha256_message_padder.sv =====
`timescale 1ns / 1ps

module tb_sha256_message_padder;
    import shapad_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [31:0] block_word;
        logic        last_word;
    } t_padded_word;

    logic i_clk;
    logic i_rst_n;

    shapad_in_if  msg_in();
    shapad_out_if word_out();

    sha256_message_padder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (msg_in),
        .o_out   (word_out)
    );

    t_padded_word       expected_words[$];
    logic [23:0]        partial_bytes;
    logic [COUNT_W-1:0] msg_bytes;
    int                 error_count = 0;
    int                 items_sent = 0;
    int                 cycle_count = 0;
    bit                 idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words still expected", $time, expected_words.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void pack_message_byte(input logic [7:0] b);
        t_padded_word w;
        if (msg_bytes[1:0] == WORD_LAST_BYTE) begin
            w.block_word = {partial_bytes, b};
            w.last_word = 1'b0;
            expected_words.push_back(w);
            partial_bytes = '0;
        end else begin
            partial_bytes = {partial_bytes[15:0], b};
        end
        msg_bytes = msg_bytes + 1'b1;
    endfunction

    function automatic void append_padding();
        logic [LEN_W-1:0] bit_len;
        t_padded_word     w;
        bit_len = {msg_bytes, 3'b000};
        pack_message_byte(PAD_MARK);
        while (msg_bytes[5:0] != LEN_POS) pack_message_byte(PAD_ZERO);
        for (int k = 7; k >= 0; k--) pack_message_byte(bit_len[8*k +: 8]);
        w = expected_words.pop_back();
        w.last_word = 1'b1;
        expected_words.push_back(w);
        partial_bytes = '0;
        msg_bytes = '0;
    endfunction

    function automatic void predict_item(input logic [7:0] data, input logic last,
                                         input logic empty);
        if (empty) begin
            append_padding();
        end else begin
            pack_message_byte(data);
            if (last) append_padding();
        end
    endfunction

    task automatic send_item(input logic [7:0] data, input logic last, input logic empty);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            msg_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        msg_in.valid <= 1'b1;
        msg_in.data_byte <= data;
        msg_in.last_byte <= last;
        msg_in.empty_message <= empty;
        @(posedge i_clk);
        while (!msg_in.ready) @(posedge i_clk);
        predict_item(data, last, empty);
        items_sent++;
    endtask

    task automatic send_message(input int len, input bit close_with_empty);
        for (int i = 0; i < len; i++) begin
            send_item(8'($urandom_range(0, 255)), !close_with_empty && (i == len - 1), 1'b0);
        end
        if (close_with_empty) begin
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    task automatic test_empty_messages();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_short_messages();
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        for (int i = 0; i < 5; i++) send_item(8'(8'h11 * (i + 1)), i == 4, 1'b0);
    endtask

    task automatic test_random_messages(input int item_target);
        int len;
        int pick;
        while (items_sent < item_target) begin
            idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 6) len = $urandom_range(0, 12);
            else if (pick < 9) len = $urandom_range(50, 70);
            else len = $urandom_range(100, 140);
            send_message(len, (len == 0) || ($urandom_range(0, 3) == 0));
        end
    endtask

    task automatic test_steady_stream(input int item_target);
        int len;
        idle_on = 1'b0;
        while (items_sent < item_target) begin
            len = $urandom_range(0, 70);
            send_message(len, (len == 0) || ($urandom_range(0, 3) == 0));
        end
    endtask

    initial begin : ready_driver
        int stall_left;
        stall_left = 0;
        word_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                word_out.ready <= (stall_left == 0);
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18);
                word_out.ready <= 1'b0;
            end else begin
                word_out.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : word_check
        t_padded_word exp_w;
        if (i_rst_n && word_out.valid && word_out.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word %h last %b", $time,
                         word_out.block_word, word_out.last_word);
                error_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (word_out.block_word !== exp_w.block_word) begin
                    $display("%0t: block_word expected %h actual %h", $time,
                             exp_w.block_word, word_out.block_word);
                    error_count++;
                end
                if (word_out.last_word !== exp_w.last_word) begin
                    $display("%0t: last_word expected %b actual %b", $time,
                             exp_w.last_word, word_out.last_word);
                    error_count++;
                end
            end
        end
    end

    initial begin
        partial_bytes = '0;
        msg_bytes = '0;
        i_rst_n = 1'b0;
        msg_in.valid = 1'b0;
        msg_in.data_byte = 8'h00;
        msg_in.last_byte = 1'b0;
        msg_in.empty_message = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_messages();
        test_short_messages();
        test_random_messages(360);
        test_steady_stream(440);

        msg_in.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/shapad_pkg.sv
hw/rtl/shapad_in_if.sv
hw/rtl/shapad_out_if.sv
hw/rtl/shapad_packer.sv
hw/rtl/shapad_seq.sv
hw/rtl/sha256_message_padder.sv
test/tb_sha256_message_padder.sv
